/* rtl/core/ilrc_pkg.sv */
`default_nettype none
package ilrc_pkg;

    // datagram position counter saturates here; all header offsets lie below it
    localparam int unsigned MAX_DATAGRAM_BYTES = 1024;
    localparam int unsigned POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned FN_W   = 6;
    localparam int unsigned VERD_W = 3;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [FN_W-1:0]   t_fn;
    typedef logic [VERD_W-1:0] t_verdict;

    localparam t_byte RMCP_VER_CODE   = 8'h06;
    localparam t_byte RMCP_IPMI_CLASS = 8'h07;
    localparam t_pos  HDR_MIN_BYTES   = t_pos'(22);
    localparam t_pos  OFS_VERSION     = t_pos'(0);
    localparam t_pos  OFS_CLASS       = t_pos'(3);
    localparam t_pos  OFS_LENGTH      = t_pos'(14);
    localparam t_pos  OFS_FUNCTION    = t_pos'(16);
    localparam t_pos  OFS_COMPLETION  = t_pos'(21);
    localparam t_byte LEN_MIN         = 8'd7;
    localparam t_byte LEN_OVERHEAD    = 8'd8;
    localparam t_fn   RESP_BIT        = 6'h01;

    localparam t_verdict V_OK         = 3'd0;
    localparam t_verdict V_SHORT      = 3'd1;
    localparam t_verdict V_VERSION    = 3'd2;
    localparam t_verdict V_CLASS      = 3'd3;
    localparam t_verdict V_OVERRUN    = 3'd4;
    localparam t_verdict V_SMALL      = 3'd5;
    localparam t_verdict V_FUNCTION   = 3'd6;
    localparam t_verdict V_COMPLETION = 3'd7;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

endpackage
`default_nettype wire

/* rtl/core/ilrc_if.sv */
`default_nettype none
interface ilrc_in_if import ilrc_pkg::*; ;
    logic  valid;
    logic  ready;
    t_byte rx_byte;
    logic  end_of_datagram;

    modport source (output valid, output rx_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input rx_byte, input end_of_datagram, output ready);
endinterface

interface ilrc_out_if import ilrc_pkg::*; ;
    logic     valid;
    logic     ready;
    logic     result_kind;
    t_byte    payload_byte;
    t_verdict verdict;
    t_byte    payload_length;
    logic     final_flag;

    modport source (output valid, output result_kind, output payload_byte, output verdict,
                    output payload_length, output final_flag, input ready);
    modport sink   (input valid, input result_kind, input payload_byte, input verdict,
                    input payload_length, input final_flag, output ready);
endinterface
`default_nettype wire

/* rtl/core/ipmi_lan_response_checker_unit.sv */
// IPMI v1.5 RMCP response checker. Feed a received UDP datagram one byte per
// item on i_rx, with end_of_datagram set on its last byte. Bytes from offset 22
// up to the trailing checksum (offset 14 + message length) come out as payload
// items as they arrive, before the datagram has been judged; the last byte
// produces one verdict item (final_flag 1) naming the first failed check, or ok
// with the payload length. Discard the payload of a datagram whose verdict is
// not ok. The header checks are byte compares made on the fly against a
// position counter, and the result sits in one output register, so a byte is
// accepted every cycle unless that register is full and not being taken.
// Write expected_function only while no datagram is in flight.
`default_nettype none
module ipmi_lan_response_checker_unit
    import ilrc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire t_fn    i_cfg_wdata,
    ilrc_in_if.sink     i_rx,
    ilrc_out_if.source  o_res
);

    t_fn   r_expected_function;
    t_pos  r_pos;
    t_byte r_msg_len;
    logic  r_version_good;
    logic  r_class_good;
    logic  r_function_good;
    logic  r_completion_good;

    logic     r_valid;
    logic     r_kind;
    t_byte    r_payload_byte;
    t_verdict r_verdict;
    t_byte    r_payload_length;
    logic     r_final;

    logic     accept;
    logic     last;
    t_byte    b;
    logic     completion_now;
    logic     is_payload;
    logic     emit;
    t_verdict verdict;
    t_byte    plen;
    t_pos     pay_end;

    assign i_rx.ready = !r_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign last       = i_rx.end_of_datagram;

    // completion code may arrive on the very last byte
    assign completion_now = (r_pos == OFS_COMPLETION) ? (b == '0) : r_completion_good;
    assign pay_end        = OFS_LENGTH + t_pos'(r_msg_len);
    assign is_payload     = (r_pos >= HDR_MIN_BYTES) && (r_pos < pay_end);
    assign emit           = last || is_payload;

    always_comb begin
        plen = '0;
        priority if (r_pos < HDR_MIN_BYTES - t_pos'(1)) begin
            verdict = V_SHORT;
        end else if (!r_version_good) begin
            verdict = V_VERSION;
        end else if (!r_class_good) begin
            verdict = V_CLASS;
        end else if (pay_end > r_pos) begin
            verdict = V_OVERRUN;
        end else if (r_msg_len < LEN_MIN) begin
            verdict = V_SMALL;
        end else if (!r_function_good) begin
            verdict = V_FUNCTION;
        end else if (!completion_now) begin
            verdict = V_COMPLETION;
        end else begin
            verdict = V_OK;
            plen    = (r_msg_len >= LEN_OVERHEAD) ? r_msg_len - LEN_OVERHEAD : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_function <= '0;
        end else if (i_cfg_we) begin
            r_expected_function <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos             <= '0;
            r_msg_len         <= '0;
            r_version_good    <= 1'b0;
            r_class_good      <= 1'b0;
            r_function_good   <= 1'b0;
            r_completion_good <= 1'b0;
        end else if (accept) begin
            if (last) begin
                r_pos             <= '0;
                r_msg_len         <= '0;
                r_version_good    <= 1'b0;
                r_class_good      <= 1'b0;
                r_function_good   <= 1'b0;
                r_completion_good <= 1'b0;
            end else begin
                if (r_pos < t_pos'(MAX_DATAGRAM_BYTES)) begin
                    r_pos <= r_pos + t_pos'(1);
                end
                if (r_pos == OFS_VERSION) begin
                    r_version_good <= (b == RMCP_VER_CODE);
                end
                if (r_pos == OFS_CLASS) begin
                    r_class_good <= (b == RMCP_IPMI_CLASS);
                end
                if (r_pos == OFS_LENGTH) begin
                    r_msg_len <= b;
                end
                if (r_pos == OFS_FUNCTION) begin
                    r_function_good <= (b[7:2] == (r_expected_function | RESP_BIT));
                end
                if (r_pos == OFS_COMPLETION) begin
                    r_completion_good <= (b == '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            if (last) begin
                r_kind           <= KIND_VERDICT;
                r_payload_byte   <= '0;
                r_verdict        <= verdict;
                r_payload_length <= plen;
                r_final          <= 1'b1;
            end else begin
                r_kind           <= KIND_PAYLOAD;
                r_payload_byte   <= b;
                r_verdict        <= V_OK;
                r_payload_length <= '0;
                r_final          <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.result_kind    = r_kind;
    assign o_res.payload_byte   = r_payload_byte;
    assign o_res.verdict        = r_verdict;
    assign o_res.payload_length = r_payload_length;
    assign o_res.final_flag     = r_final;

endmodule
`default_nettype wire
